/* sv/q32_pkg.sv */
// shared types, opcodes and constants for the q32.32 arithmetic unit
`default_nettype none
package q32_pkg;
    localparam int FracBits = 32;
    localparam int WordBits = 64;
    localparam int RootSteps = (WordBits + FracBits) / 2;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_SQRT = 4'd4, OP_ABS = 4'd5, OP_NEG = 4'd6, OP_MIN = 4'd7,
        OP_MAX = 4'd8, OP_FLOOR = 4'd9, OP_CEIL = 4'd10, OP_FRACT = 4'd11,
        OP_ROUND = 4'd12, OP_MOD = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0, ERR_OVF = 2'd1, ERR_DIVZ = 2'd2, ERR_DOM = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ITER, ST_FIN, ST_OUT
    } state_t;

    // unit selection for multicycle work
    typedef enum logic [1:0] {
        U_DIV = 2'd0, U_SQRT = 2'd1, U_MOD = 2'd2
    } unit_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   mul_step;
        logic   iter_step;
        logic   finish;
        unit_t  unit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic   multi;
        logic   is_mul;
        logic   unit_mod;
        logic   unit_sqrt;
    } stat_t;
endpackage
`default_nettype wire

/* sv/q32_ctrl.sv */
// controller state machine sequencing one operation at a time
`default_nettype none
module q32_ctrl
    import q32_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_xfer,
    input  wire logic  out_xfer,
    input  wire stat_t stat,
    output logic       busy,
    output logic       out_valid,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    unit_t unit_reg, unit_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            unit_reg <= U_DIV;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            unit_reg <= unit_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unit_next = unit_reg;
        cmd = '0;
        cmd.unit = unit_reg;
        busy = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (in_xfer) begin
                    cmd.load = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // decoded operation is registered now
                if (stat.is_mul) begin
                    cmd.mul_step = 1'b1;
                    state_next = ST_FIN;
                end else if (stat.multi) begin
                    unit_next = stat.unit_sqrt ? U_SQRT : (stat.unit_mod ? U_MOD : U_DIV);
                    cnt_next = '0;
                    state_next = ST_ITER;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_ITER: begin
                cmd.iter_step = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if ((unit_reg == U_SQRT && cnt_reg == 7'(RootSteps - 1)) ||
                    cnt_reg == 7'(WordBits - 1))
                    state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_xfer) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/q32_dp.sv */
// datapath: operand registers, multiplier, shared shift-subtract unit
`default_nettype none
module q32_dp
    import q32_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [3:0]  in_kind,
    input  wire logic [63:0] in_a,
    input  wire logic [63:0] in_b,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    output logic [63:0]      res_value,
    output logic [1:0]       res_err
);
    localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FracMask = (64'd1 << FracBits) - 64'd1;
    localparam logic [63:0] HalfLsb = 64'd1 << (FracBits - 1);

    logic [3:0]  kind_reg;
    logic [63:0] a_reg, b_reg, ua_reg, ub_reg;
    logic        neg_reg;
    logic [63:0] rem_reg, low_reg, q_reg;
    logic [63:0] hh_reg, hl_reg, lh_reg, ll_reg;
    logic [63:0] value_reg;
    logic [1:0]  err_reg;

    logic [63:0] ua_c, ub_c;
    logic [64:0] rsh_c;
    logic [63:0] trial_c;
    logic        take_c;
    logic [65:0] rem_sq_c;

    logic [63:0] fin_v, mag_c, s_c, mid_c, lo1_c, lo2_c;
    logic [1:0]  fin_e;
    logic        hi_c;
    logic [64:0] sum1_c, sum2_c;
    logic        mneg_c;

    assign ua_c = in_a[63] ? (~in_a + 64'd1) : in_a;
    assign ub_c = in_b[63] ? (~in_b + 64'd1) : in_b;

    // status decode
    always_comb begin
        stat.is_mul = (kind_reg == OP_MUL);
        stat.unit_sqrt = (kind_reg == OP_SQRT) && !a_reg[63];
        stat.unit_mod = (kind_reg == OP_MOD) && !b_reg[63] && (b_reg != '0);
        stat.multi = stat.unit_sqrt || stat.unit_mod ||
                     ((kind_reg == OP_DIV) && (b_reg != '0) &&
                      ((ua_reg >> (WordBits - FracBits)) < ub_reg));
    end

    // one shift-subtract step for divide, remainder and root
    always_comb begin
        rsh_c = {rem_reg, low_reg[63]};
        rem_sq_c = {rem_reg, low_reg[63:62]};
        trial_c = {q_reg[61:0], 2'b01};
        take_c = 1'b0;
        case (cmd.unit)
            U_SQRT: take_c = (rem_sq_c >= {2'b00, trial_c}) && (q_reg[63:62] == 2'b00);
            default: take_c = rsh_c[64] || (rsh_c[63:0] >= ub_reg);
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            a_reg <= in_a;
            b_reg <= in_b;
            ua_reg <= ua_c;
            ub_reg <= ub_c;
            neg_reg <= in_a[63] ^ in_b[63];
        end
        if (cmd.mul_step) begin
            hh_reg <= ua_reg[63:32] * ub_reg[63:32];
            hl_reg <= ua_reg[63:32] * ub_reg[31:0];
            lh_reg <= ua_reg[31:0] * ub_reg[63:32];
            ll_reg <= ua_reg[31:0] * ub_reg[31:0];
        end
        if (!cmd.iter_step && !cmd.load && !cmd.mul_step && !cmd.finish) begin
            // seed iteration registers whenever no command is active, as in the decode state
            case (kind_reg)
                OP_SQRT: begin
                    rem_reg <= '0;
                    low_reg <= a_reg << (WordBits - RootSteps * 2 + FracBits);
                    q_reg <= '0;
                end
                OP_MOD: begin
                    rem_reg <= '0;
                    low_reg <= ua_reg;
                    q_reg <= '0;
                end
                default: begin
                    rem_reg <= ua_reg >> (WordBits - FracBits);
                    low_reg <= ua_reg << FracBits;
                    q_reg <= '0;
                end
            endcase
        end
        if (cmd.iter_step) begin
            if (cmd.unit == U_SQRT) begin
                low_reg <= low_reg << 2;
                rem_reg <= take_c ? (rem_sq_c[63:0] - trial_c) : rem_sq_c[63:0];
                q_reg <= {q_reg[62:0], take_c};
            end else begin
                low_reg <= low_reg << 1;
                rem_reg <= take_c ? (rsh_c[63:0] - ub_reg) : rsh_c[63:0];
                q_reg <= {q_reg[62:0], take_c};
            end
        end
        if (cmd.finish) begin
            value_reg <= fin_v;
            err_reg <= fin_e;
        end
    end

    // result selection
    always_comb begin
        fin_v = '0;
        fin_e = ERR_OK;
        mag_c = '0;
        mneg_c = neg_reg;
        s_c = '0;
        mid_c = hl_reg + lh_reg;
        sum1_c = {1'b0, hh_reg << 32} + {1'b0, mid_c};
        lo1_c = sum1_c[63:0];
        sum2_c = {1'b0, lo1_c} + {33'd0, ll_reg[63:32]};
        lo2_c = sum2_c[63:0];
        hi_c = (hh_reg[63:32] != '0) || sum1_c[64] || sum2_c[64] ||
               ((hl_reg + lh_reg) < hl_reg) ;
        case (kind_reg)
            OP_ADD: fin_v = a_reg + b_reg;
            OP_SUB: fin_v = a_reg - b_reg;
            OP_MUL: begin
                if (hi_c) begin
                    fin_e = ERR_OVF;
                    fin_v = neg_reg ? SignBit : MaxPos;
                end else
                    mag_c = lo2_c;
            end
            OP_DIV: begin
                if (b_reg == '0) fin_e = ERR_DIVZ;
                else if ((ua_reg >> (WordBits - FracBits)) >= ub_reg) begin
                    fin_e = ERR_OVF;
                    fin_v = neg_reg ? SignBit : MaxPos;
                end else mag_c = q_reg;
            end
            OP_SQRT: begin
                if (a_reg[63]) fin_e = ERR_DOM;
                else fin_v = q_reg;
            end
            OP_ABS: begin mneg_c = 1'b0; mag_c = ua_reg; end
            OP_NEG: begin mneg_c = !a_reg[63]; mag_c = ua_reg; end
            OP_MIN: fin_v = ($signed(b_reg) < $signed(a_reg)) ? b_reg : a_reg;
            OP_MAX: fin_v = ($signed(b_reg) < $signed(a_reg)) ? a_reg : b_reg;
            OP_FLOOR: fin_v = a_reg & ~FracMask;
            OP_CEIL, OP_ROUND: begin
                s_c = a_reg + ((kind_reg == OP_CEIL) ? FracMask : HalfLsb);
                if (!a_reg[63] && s_c[63]) begin
                    fin_e = ERR_OVF;
                    fin_v = MaxPos;
                end else fin_v = s_c & ~FracMask;
            end
            OP_FRACT: fin_v = a_reg & FracMask;
            OP_MOD: begin
                if (b_reg[63] || b_reg == '0) fin_e = ERR_DOM;
                else fin_v = a_reg[63] ? (~rem_reg + 64'd1) : rem_reg;
            end
            default: fin_e = ERR_DOM;
        endcase
        // signed result from magnitude for mul, div, abs, neg
        if (fin_e == ERR_OK && (kind_reg == OP_MUL || kind_reg == OP_DIV ||
                                kind_reg == OP_ABS || kind_reg == OP_NEG)) begin
            if (mneg_c) begin
                if (mag_c > SignBit) begin fin_e = ERR_OVF; fin_v = SignBit; end
                else fin_v = ~mag_c + 64'd1;
            end else begin
                if (mag_c > MaxPos) begin fin_e = ERR_OVF; fin_v = MaxPos; end
                else fin_v = mag_c;
            end
        end
    end

    assign res_value = value_reg;
    assign res_err = err_reg;
endmodule
`default_nettype wire

/* sv/q32_32_fixed_point_alu.sv */
// top level of the signed q32.32 arithmetic unit
// path from input transfer to result: simple ops, multiply and operands flagged at decode
// pass the decode, finish and output states; divide, remainder and square root add iteration
// steps between decode and finish (one quotient or root bit per cycle in the shared shift-subtract unit)
// one item at a time, next accepted the cycle after the result transfer;
// synchronous active-low reset returns the controller to idle
`default_nettype none
module q32_32_fixed_point_alu
    import q32_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // operand_a[63:0], operand_b[127:64]
    input  wire logic [3:0]   s_tuser,  // kind[3:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata   // value[63:0], error_code[65:64]
);
    cmd_t  cmd;
    stat_t stat;
    logic  busy;
    logic [63:0] value;
    logic [1:0]  err;

    assign s_tready = !busy;

    q32_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_xfer(s_tvalid && s_tready), .out_xfer(m_tvalid && m_tready),
        .stat(stat), .busy(busy), .out_valid(m_tvalid), .cmd(cmd)
    );

    q32_dp u_dp (
        .aclk(aclk), .in_kind(s_tuser), .in_a(s_tdata[63:0]),
        .in_b(s_tdata[127:64]), .cmd(cmd), .stat(stat),
        .res_value(value), .res_err(err)
    );

    assign m_tdata = {6'd0, err, value};
endmodule
`default_nettype wire

/* tb/sv/q32_32_fixed_point_alu_tb.sv */
// self-checking testbench for the signed q32.32 arithmetic unit
`default_nettype none
module q32_32_fixed_point_alu_tb;
    import q32_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FracMask = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] HalfLsb = 64'h0000_0000_8000_0000;
    localparam int CycleLimit = 1_000_000;
    localparam int RandomItems = 1650;
    localparam int HoldCycles = 400;

    typedef struct packed {
        logic [63:0] b;
        logic [63:0] a;
        logic [3:0]  kind;
    } alu_req_t;

    typedef struct packed {
        err_t        err;
        logic [63:0] value;
    } alu_rsp_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    alu_req_t pending_reqs[$];
    alu_rsp_t expected_rsps[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_req;
    int       hold_seen;
    int       hold_left;
    bit       pause_send;

    q32_32_fixed_point_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] mag(logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic [63:0] signed_of(bit neg, logic [63:0] m, ref err_t err);
        if (neg) begin
            if (m > SignBit) begin
                err = ERR_OVF;
                return SignBit;
            end
            return ~m + 64'd1;
        end
        if (m > MaxPos) begin
            err = ERR_OVF;
            return MaxPos;
        end
        return m;
    endfunction

    // expected value and error code for one request
    function automatic alu_rsp_t alu_result(alu_req_t r);
        logic [63:0]  a, b, v, s, ua, ub, rem, q, root, trial;
        logic [127:0] prod, num;
        err_t         err;
        bit           neg;
        alu_rsp_t     o;
        a = r.a;
        b = r.b;
        v = '0;
        err = ERR_OK;
        neg = a[63] != b[63];
        case (r.kind)
            OP_ADD: v = a + b;
            OP_SUB: v = a - b;
            OP_MUL: begin
                prod = {64'd0, mag(a)} * {64'd0, mag(b)};
                if (prod[127:96] != 0) begin
                    err = ERR_OVF;
                    v = neg ? SignBit : MaxPos;
                end else begin
                    v = signed_of(neg, prod[95:32], err);
                end
            end
            OP_DIV: begin
                if (b == 0) begin
                    err = ERR_DIVZ;
                end else begin
                    ua = mag(a);
                    ub = mag(b);
                    if ((ua >> 32) >= ub) begin
                        err = ERR_OVF;
                        v = neg ? SignBit : MaxPos;
                    end else begin
                        num = {32'd0, ua, 32'd0};
                        q = 64'(num / {64'd0, ub});
                        v = signed_of(neg, q, err);
                    end
                end
            end
            OP_SQRT: begin
                if (a[63]) begin
                    err = ERR_DOM;
                end else begin
                    rem = '0;
                    root = '0;
                    num = {32'd0, a, 32'd0};
                    for (int i = 47; i >= 0; i--) begin
                        rem = (rem << 2) | 64'(num[2*i +: 2]);
                        trial = (root << 2) | 64'd1;
                        if (rem >= trial) begin
                            rem -= trial;
                            root = (root << 1) | 64'd1;
                        end else begin
                            root = root << 1;
                        end
                    end
                    v = root;
                end
            end
            OP_ABS: v = signed_of(1'b0, mag(a), err);
            OP_NEG: v = signed_of(!a[63], mag(a), err);
            OP_MIN: v = ($signed(b) < $signed(a)) ? b : a;
            OP_MAX: v = ($signed(b) < $signed(a)) ? a : b;
            OP_FLOOR: v = a & ~FracMask;
            OP_CEIL, OP_ROUND: begin
                s = a + ((r.kind == OP_CEIL) ? FracMask : HalfLsb);
                if (!a[63] && s[63]) begin
                    err = ERR_OVF;
                    v = MaxPos;
                end else begin
                    v = s & ~FracMask;
                end
            end
            OP_FRACT: v = a & FracMask;
            OP_MOD: begin
                if (b[63] || b == 0) begin
                    err = ERR_DOM;
                end else begin
                    rem = mag(a) % b;
                    v = a[63] ? (~rem + 64'd1) : rem;
                end
            end
            default: err = ERR_DOM;
        endcase
        o.value = v;
        o.err = err;
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] x;
        x = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: x = SignBit;
            1: x = MaxPos;
            2: x = 64'(signed'(32'($urandom_range(0, 7)) - 32'sd3)) << 32;
            3: x = {{32{x[63]}}, x[31:0]};
            4: x = {32'(signed'(16'(x[47:32]))), x[31:0]};
            5: x = {x[63:32], 32'h8000_0000};
            default: ;
        endcase
        return x;
    endfunction

    task automatic push_req(logic [3:0] kind, logic [63:0] a, logic [63:0] b);
        alu_req_t r;
        r.kind = kind;
        r.a = a;
        r.b = b;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0)
            @(posedge aclk);
    endtask

    // driver: offer queued requests, random gaps
    always @(posedge aclk) begin
        alu_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_rsps.push_back(alu_result(alu_req_t'({s_tdata, s_tuser})));
            if (pending_reqs.size() != 0 && !pause_send
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                s_tdata <= {nxt.b, nxt.a};
                s_tuser <= nxt.kind;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off counted down here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HoldCycles;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        alu_rsp_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = alu_rsp_t'(m_tdata[65:0]);
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h err=%0d", got.value, got.err);
            end else begin
                want = expected_rsps.pop_front();
                if (got.value !== want.value || got.err !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%h err=%0d, got value=%h err=%0d",
                                 want.value, want.err, got.value, got.err);
                end
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("q32_32_fixed_point_alu_tb: FAIL");
            $finish;
        end
    end

    initial begin
        op_t k;
        aresetn = 1'b0;
        hold_req = 0;
        pause_send = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 70;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every operation plus the saturation and error cases
        k = k.first();
        do begin
            push_req(k, 64'h0000_0003_8000_0000, 64'hFFFF_FFFE_4000_0000);
            k = k.next();
        end while (k != k.first());
        push_req(OP_MUL, MaxPos, MaxPos);
        push_req(OP_MUL, SignBit, 64'h0000_0001_0000_0000);
        push_req(OP_DIV, MaxPos, 64'd0);
        push_req(OP_DIV, MaxPos, 64'd1);
        push_req(OP_SQRT, MaxPos, 64'd0);
        push_req(OP_SQRT, SignBit, 64'd0);
        push_req(OP_ABS, SignBit, 64'd0);
        push_req(OP_NEG, SignBit, 64'd0);
        push_req(OP_CEIL, MaxPos, 64'd0);
        push_req(OP_ROUND, MaxPos, 64'd0);
        push_req(OP_FLOOR, SignBit, 64'd0);
        push_req(OP_MOD, 64'hFFFF_FFF9_0000_0000, 64'd0);
        push_req(OP_MOD, 64'h0000_0007_0000_0000, SignBit);
        push_req(4'd14, MaxPos, MaxPos);
        push_req(4'd15, 64'd0, 64'd0);
        drain();

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 33 : 0;
            for (int n = 0; n < RandomItems / 3; n++) begin
                push_req(4'($urandom_range(0, 15)), rand64(), rand64());
                if (n == 100) begin
                    // sender waits for every pending result
                    while (pending_reqs.size() != 0 || s_tvalid) @(posedge aclk);
                    pause_send = 1'b1;
                    while (expected_rsps.size() != 0) @(posedge aclk);
                    pause_send = 1'b0;
                end
                if (phase == 0 && n == 200) begin
                    hold_req++;
                end
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("q32_32_fixed_point_alu_tb: PASS");
        end else begin
            $display("q32_32_fixed_point_alu_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
